>>> src/rvie_pkg.sv
// Package with opcodes, register indexes and shared types for the instruction executor.
`timescale 1ns / 1ps
package rvie_pkg;

   localparam int DataWidthDefault = 32;
   localparam int NumRegs = 20;
   localparam int RegIdxWidth = 5;
   localparam int WordWidth = 32;
   localparam int QueueDepth = 2;

   localparam logic [4:0] IdxPc = 5'd16;
   localparam logic [4:0] IdxRmdr = 5'd17;
   localparam logic [4:0] IdxCond = 5'd18;
   localparam logic [4:0] IdxComp = 5'd19;

   localparam logic [2:0] CmpGreater = 3'd1;
   localparam logic [2:0] CmpEqual = 3'd2;
   localparam logic [2:0] CmpLess = 3'd4;

   typedef enum logic [7:0] {
      OP_LOAD           = 8'd3,
      OP_ADD            = 8'd4,
      OP_SUB            = 8'd5,
      OP_MUL            = 8'd6,
      OP_DIV            = 8'd7,
      OP_JMP_ABS        = 8'd8,
      OP_JMP_FWD        = 8'd9,
      OP_JMP_BACK       = 8'd10,
      OP_REG_JMP_ABS    = 8'd11,
      OP_REG_JMP_FWD    = 8'd12,
      OP_REG_JMP_BACK   = 8'd13,
      OP_EQL            = 8'd14,
      OP_NQL            = 8'd15,
      OP_GTE            = 8'd16,
      OP_LTE            = 8'd17,
      OP_CMP            = 8'd18,
      OP_REG_JMP_TRUE   = 8'd19,
      OP_REG_JMP_FALSE  = 8'd20,
      OP_JMP_TRUE       = 8'd21,
      OP_JMP_FALSE      = 8'd22,
      OP_GTX            = 8'd23,
      OP_LTX            = 8'd24
   } opcode_type;

   // Decoded word handed from the front to the back.
   typedef struct packed {
      logic [7:0]             op;
      logic [RegIdxWidth-1:0] r1;
      logic [RegIdxWidth-1:0] r2;
      logic [RegIdxWidth-1:0] rd;
      logic [15:0]            imm;
      logic                   illegal;
   } decoded_type;

endpackage

>>> src/rvie_channel_if.sv
// Valid/ready channel interfaces for instruction and result words.
`timescale 1ns / 1ps
interface rvie_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;
   modport source (output valid, output instruction_word, input ready);
   modport sink (input valid, input instruction_word, output ready);
endinterface

interface rvie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] program_counter;
   logic        condition_flag;
   logic [2:0]  compare_code;
   logic [31:0] remainder_value;
   logic        write_enable;
   logic [4:0]  write_index;
   logic [31:0] write_data;
   logic        illegal_flag;
   modport source (output valid, output program_counter, output condition_flag,
                   output compare_code, output remainder_value, output write_enable,
                   output write_index, output write_data, output illegal_flag,
                   input ready);
   modport sink (input valid, input program_counter, input condition_flag,
                 input compare_code, input remainder_value, input write_enable,
                 input write_index, input write_data, input illegal_flag,
                 output ready);
endinterface

>>> src/register_vm_instruction_execute.sv
// Top level of the register machine instruction executor.
// Usage:
//   The req channel carries one 32-bit instruction word per transfer; the rsp
//   channel returns exactly one result word per instruction, in order: PC,
//   condition, compare code, remainder, the register write and an illegal flag.
//   A front end decodes and checks register indexes into a two-entry queue;
//   the back end reads the register file, executes and writes back.
//   A word goes from acceptance through the operand read, execute and wait
//   states to rsp valid; a divide by a nonzero divisor adds the divide state,
//   run by the one-bit-a-cycle divider. The back end takes one word at a time
//   and takes no new word until the previous result word has been taken.
//   Reset (synchronous, active high) clears all 20 registers, the front queue
//   and any pending result.
//   When the receiver holds rsp.ready low the result word stays stable; the
//   back end then stops and the front queue keeps taking up to two words.
`timescale 1ns / 1ps
module register_vm_instruction_execute #(
   parameter int DATA_WIDTH = rvie_pkg::DataWidthDefault
) (
   input logic        clock,
   input logic        reset,
   rvie_req_if.sink   req,
   rvie_rsp_if.source rsp
);
   import rvie_pkg::*;

   logic        dec_valid, dec_ready;
   decoded_type dec_word;

   rvie_decode u_decode (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_instruction_word(req.instruction_word),
      .dec_valid(dec_valid), .dec_ready(dec_ready), .dec_word(dec_word)
   );

   rvie_execute #(.DATA_WIDTH(DATA_WIDTH)) u_execute (
      .clock(clock), .reset(reset),
      .dec_valid(dec_valid), .dec_ready(dec_ready), .dec_word(dec_word),
      .rsp(rsp)
   );
endmodule

>>> src/rvie_decode.sv
// Front end: accepts instruction words, decodes them and checks register indexes.
`timescale 1ns / 1ps
module rvie_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_instruction_word,
   output logic                 dec_valid,
   input  logic                 dec_ready,
   output rvie_pkg::decoded_type dec_word
);
   import rvie_pkg::*;

   logic                      q_valid_ff [QueueDepth];
   logic                      q_valid_in [QueueDepth];
   decoded_type               q_data_ff  [QueueDepth];
   decoded_type               q_data_in  [QueueDepth];
   decoded_type               fresh;
   logic [7:0]                op, f1, f2, fd;
   logic                      ok1, ok2, okd;

   // Decode and index checks on the incoming word.
   always_comb begin
      op = req_instruction_word[31:24];
      f1 = req_instruction_word[23:16];
      f2 = req_instruction_word[15:8];
      fd = req_instruction_word[7:0];
      ok1 = f1 < 8'(NumRegs);
      ok2 = f2 < 8'(NumRegs);
      okd = fd < 8'(NumRegs);
      fresh.op = op;
      fresh.r1 = f1[RegIdxWidth-1:0];
      fresh.r2 = f2[RegIdxWidth-1:0];
      fresh.rd = fd[RegIdxWidth-1:0];
      fresh.imm = req_instruction_word[15:0];
      unique case (op) inside
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: fresh.illegal = !(ok1 && ok2 && okd);
         OP_EQL, OP_NQL, OP_GTE, OP_LTE, OP_CMP, OP_GTX, OP_LTX:
            fresh.illegal = !(ok1 && ok2);
         OP_LOAD, OP_REG_JMP_ABS, OP_REG_JMP_FWD, OP_REG_JMP_BACK, OP_REG_JMP_TRUE,
         OP_REG_JMP_FALSE:
            fresh.illegal = !ok1;
         OP_JMP_ABS, OP_JMP_FWD, OP_JMP_BACK, OP_JMP_TRUE, OP_JMP_FALSE:
            fresh.illegal = 1'b0;
         default: fresh.illegal = 1'b1;
      endcase
   end

   // Two-entry queue: slot 0 is the head.
   assign req_ready = !q_valid_ff[QueueDepth-1];
   assign dec_valid = q_valid_ff[0];
   assign dec_word = q_data_ff[0];

   always_comb begin
      logic pop, push;
      pop = q_valid_ff[0] && dec_ready;
      push = req_valid && req_ready;
      q_valid_in[0] = q_valid_ff[0];
      q_valid_in[1] = q_valid_ff[1];
      q_data_in[0] = q_data_ff[0];
      q_data_in[1] = q_data_ff[1];
      if (pop) begin
         q_valid_in[0] = q_valid_ff[1];
         q_data_in[0] = q_data_ff[1];
         q_valid_in[1] = 1'b0;
      end
      if (push) begin
         if (!q_valid_in[0]) begin
            q_valid_in[0] = 1'b1;
            q_data_in[0] = fresh;
         end else begin
            q_valid_in[1] = 1'b1;
            q_data_in[1] = fresh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff[0] <= 1'b0;
         q_valid_ff[1] <= 1'b0;
      end else begin
         q_valid_ff[0] <= q_valid_in[0];
         q_valid_ff[1] <= q_valid_in[1];
      end
      q_data_ff[0] <= q_data_in[0];
      q_data_ff[1] <= q_data_in[1];
   end

`ifndef SYNTHESIS
   a_tail_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff[1] |-> q_valid_ff[0]) else $error("queue tail without head");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff[1] |-> !req_ready) else $error("ready while queue full");
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff[0] && !dec_ready |=> q_valid_ff[0] && $stable(q_data_ff[0]))
      else $error("stalled head changed");
`endif
endmodule

>>> src/rvie_divider.sv
// Radix-2 restoring divider, one quotient bit a cycle.
`timescale 1ns / 1ps
module rvie_divider #(
   parameter int DATA_WIDTH = rvie_pkg::DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);
   localparam int CntWidth = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, div_ff, div_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   trial;

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

   // One shift-and-subtract step per cycle.
   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DATA_WIDTH-1]} - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CntWidth'(DATA_WIDTH);
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         if (trial[DATA_WIDTH]) begin
            rem_in = {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a running divide");
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(start) == 1'b0)
      else $error("divider count inconsistent");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
`endif
endmodule

>>> src/rvie_execute.sv
// Back end: register file, arithmetic, jumps, comparisons and the result register.
`timescale 1ns / 1ps
module rvie_execute #(
   parameter int DATA_WIDTH = rvie_pkg::DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  dec_valid,
   output logic                  dec_ready,
   input  rvie_pkg::decoded_type dec_word,
   rvie_rsp_if.source            rsp
);
   import rvie_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] regs_ff [NumRegs];
   decoded_type           cur_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;
   logic [DATA_WIDTH-1:0] prod_ff;
   logic                  out_valid_ff;
   logic                  we_ff, wr_ff;
   logic [4:0]            widx_ff;
   logic [DATA_WIDTH-1:0] wdata_ff;
   logic                  rmdr_wr_ff;
   logic [DATA_WIDTH-1:0] rmdr_data_ff;
   logic                  ill_ff;
   logic                  div_start, div_done;
   logic [DATA_WIDTH-1:0] div_q, div_r;

   rvie_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(a_ff), .divisor(b_ff), .done(div_done),
      .quotient(div_q), .remainder(div_r)
   );

   assign dec_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign div_start = (state_ff == ST_EXEC) && (cur_ff.op == OP_DIV) &&
                      !cur_ff.illegal && (b_ff != '0);

   // Result word: PC, condition, compare code, remainder and write data come straight from the architectural registers.
   assign rsp.valid = out_valid_ff;
   assign rsp.program_counter = WordWidth'(regs_ff[IdxPc]);
   assign rsp.condition_flag = regs_ff[IdxCond] != '0;
   assign rsp.compare_code = regs_ff[IdxComp][2:0];
   assign rsp.remainder_value = WordWidth'(regs_ff[IdxRmdr]);
   assign rsp.write_enable = we_ff;
   assign rsp.write_index = we_ff ? widx_ff : 5'd0;
   assign rsp.write_data = we_ff ? WordWidth'(regs_ff[widx_ff]) : 32'd0;
   assign rsp.illegal_flag = ill_ff;

   // Combinational results of the current word.
   logic                  cond;
   logic                  c_we;
   logic [4:0]            c_idx;
   logic [DATA_WIDTH-1:0] c_data, pc, imm;
   always_comb begin
      cond = regs_ff[IdxCond] != '0;
      pc = regs_ff[IdxPc];
      imm = DATA_WIDTH'(cur_ff.imm);
      c_we = 1'b1;
      c_idx = IdxPc;
      c_data = '0;
      unique case (cur_ff.op)
         OP_LOAD:  begin c_idx = cur_ff.r1; c_data = imm; end
         OP_ADD:   begin c_idx = cur_ff.rd; c_data = a_ff + b_ff; end
         OP_SUB:   begin c_idx = cur_ff.rd; c_data = a_ff - b_ff; end
         OP_MUL:   begin c_idx = cur_ff.rd; c_data = prod_ff; end
         OP_DIV:   begin c_idx = cur_ff.rd; c_data = '1; end
         OP_JMP_ABS:      c_data = imm;
         OP_JMP_FWD:      c_data = pc + imm;
         OP_JMP_BACK:     c_data = pc - imm;
         OP_REG_JMP_ABS:  c_data = a_ff;
         OP_REG_JMP_FWD:  c_data = pc + a_ff;
         OP_REG_JMP_BACK: c_data = pc - a_ff;
         OP_EQL:   begin c_idx = IdxCond; c_data = DATA_WIDTH'(a_ff == b_ff); end
         OP_NQL:   begin c_idx = IdxCond; c_data = DATA_WIDTH'(a_ff != b_ff); end
         OP_GTE:   begin c_idx = IdxCond; c_data = DATA_WIDTH'(a_ff >= b_ff); end
         OP_LTE:   begin c_idx = IdxCond; c_data = DATA_WIDTH'(a_ff <= b_ff); end
         OP_GTX:   begin c_idx = IdxCond; c_data = DATA_WIDTH'(a_ff > b_ff); end
         OP_LTX:   begin c_idx = IdxCond; c_data = DATA_WIDTH'(a_ff < b_ff); end
         OP_CMP: begin
            c_idx = IdxComp;
            c_data = DATA_WIDTH'((a_ff == b_ff) ? CmpEqual :
                                 (a_ff > b_ff) ? CmpGreater : CmpLess);
         end
         OP_REG_JMP_TRUE:  begin c_we = cond; c_data = a_ff; end
         OP_REG_JMP_FALSE: begin c_we = !cond; c_data = a_ff; end
         OP_JMP_TRUE:      begin c_we = cond; c_data = pc + imm; end
         OP_JMP_FALSE:     begin c_we = !cond; c_data = pc + imm; end
         default:  c_we = 1'b0;
      endcase
      if (cur_ff.illegal) c_we = 1'b0;
   end

   // Sequencer: read operands, execute (then divide if needed), then hold the result.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (dec_valid && dec_ready) state_in = ST_EXEC;
         ST_EXEC: state_in = div_start ? ST_DIV : ST_WAIT;
         ST_DIV:  if (div_done) state_in = ST_WAIT;
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         wr_ff <= 1'b0;
         rmdr_wr_ff <= 1'b0;
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         wr_ff <= 1'b0;
         rmdr_wr_ff <= 1'b0;
         if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && dec_valid && dec_ready) begin
            cur_ff <= dec_word;
            a_ff <= regs_ff[dec_word.r1];
            b_ff <= regs_ff[dec_word.r2];
         end
         if (state_ff == ST_EXEC) begin
            prod_ff <= a_ff * b_ff;
            we_ff <= c_we;
            widx_ff <= c_idx;
            ill_ff <= cur_ff.illegal;
            wdata_ff <= c_data;
            if (!div_start) begin
               wr_ff <= c_we && (cur_ff.op != OP_MUL);
               rmdr_wr_ff <= (cur_ff.op == OP_DIV) && !cur_ff.illegal;
               rmdr_data_ff <= a_ff;
            end
         end
         if (state_ff == ST_DIV && div_done) begin
            wr_ff <= 1'b1;
            wdata_ff <= div_q;
            rmdr_wr_ff <= 1'b1;
            rmdr_data_ff <= div_r;
         end
         // The multiply result is written in the wait state from its own product register.
         if (state_ff == ST_WAIT) begin
            if (cur_ff.op == OP_MUL && we_ff) regs_ff[widx_ff] <= prod_ff;
            out_valid_ff <= 1'b1;
         end
         // A remainder destination keeps the remainder, so the quotient write gives way.
         if (wr_ff && !(rmdr_wr_ff && widx_ff == IdxRmdr)) regs_ff[widx_ff] <= wdata_ff;
         if (rmdr_wr_ff) regs_ff[IdxRmdr] <= rmdr_data_ff;
      end
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_result_after_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_WAIT)
      else $error("result raised outside the wait state");
   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !dec_ready) else $error("front accepted while busy");
   a_illegal_no_write: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ill_ff |-> !we_ff) else $error("illegal word wrote");
`endif
endmodule
